@@ design/gmdfw_pkg.sv @@
package gmdfw_pkg;

	// Grid geometry.
	localparam int MAX_DIM = 16;
	localparam int CELLS   = MAX_DIM * MAX_DIM;
	localparam int COORD_W = $clog2(MAX_DIM);
	localparam int IDX_W   = $clog2(CELLS);
	localparam int DEPTH_W = $clog2(CELLS + 1);
	localparam int DIR_W   = 3;
	localparam int DIM_W   = 5;

	// Command codes carried on the input tuser.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_NEXT  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	// Neighbour directions, in the order they are tried.
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

	// One stack entry: a cell and the next direction to try from it.
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [DIR_W-1:0]   dir;
	} frame_t;

	// Requests from the sequencer to the wall and visited store.
	typedef struct packed {
		logic             wall_we;
		logic             wall_bit;
		logic [IDX_W-1:0] wall_addr;
		logic             vis_clear;
		logic             vis_set;
		logic [IDX_W-1:0] vis_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} grid_req_t;

	// Registered read data from the store.
	typedef struct packed {
		logic wall;
		logic visited;
	} grid_rsp_t;

	// Linear cell address, row major.
	function automatic logic [IDX_W-1:0] cell_index(input logic [COORD_W-1:0] row,
			input logic [COORD_W-1:0] col);
		cell_index = IDX_W'(row) * IDX_W'(MAX_DIM) + IDX_W'(col);
	endfunction

endpackage

@@ design/gmdfw_grid_store.sv @@
module gmdfw_grid_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gmdfw_pkg::grid_req_t req,
	output gmdfw_pkg::grid_rsp_t rsp
);

	logic                           wall_mem [gmdfw_pkg::CELLS];
	logic [gmdfw_pkg::CELLS-1:0]    visited_q;
	logic                           wall_rd_q;
	logic                           vis_rd_q;

	// Wall memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (req.wall_we) begin
			wall_mem[req.wall_addr] <= req.wall_bit;
		end
		if (req.rd_en) begin
			wall_rd_q <= wall_mem[req.rd_addr];
		end
	end

	// Visited flags: cleared at once by reset or start, set one cell at a time.
	// A start clears the flags and marks the requested cell in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
		end else begin
			if (req.vis_clear) begin
				visited_q <= gmdfw_pkg::CELLS'(req.vis_set) << req.vis_addr;
			end else if (req.vis_set) begin
				visited_q[req.vis_addr] <= 1'b1;
			end
		end
	end

	// Registered read of the visited flag, aligned with the wall read.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			vis_rd_q <= visited_q[req.rd_addr];
		end
	end

	assign rsp.wall    = wall_rd_q;
	assign rsp.visited = vis_rd_q;

endmodule

@@ design/gmdfw_stack.sv @@
module gmdfw_stack (
	input  logic                        clk,
	input  logic                        we,
	input  logic [gmdfw_pkg::IDX_W-1:0] waddr,
	input  gmdfw_pkg::frame_t           wdata,
	input  logic                        re,
	input  logic [gmdfw_pkg::IDX_W-1:0] raddr,
	output gmdfw_pkg::frame_t           rdata
);

	gmdfw_pkg::frame_t stack_mem [gmdfw_pkg::CELLS];
	gmdfw_pkg::frame_t rdata_q;

	// Entries below the top of the walk; the top itself lives in a register.
	always_ff @(posedge clk) begin
		if (we) begin
			stack_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= stack_mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/grid_maze_depth_first_walk_core.sv @@
// Depth-first walk of a grid maze, trying up, right, down and left in turn.
// Input items arrive on s_tvalid/s_tready; tuser carries the command (load,
// start or next) and tdata the cell and wall bit of a load. A load writes one
// wall bit and gives no result. A start clears the visited flags, enters the
// origin and returns it through the emit state and the output register. A next item returns the
// next newly visited cell, or an item with tlast high when the walk is over.
// Results leave on m_tvalid/m_tready from an output register; while it is
// occupied the block keeps working and only holds the following result.
// A next item probes each neighbour that lies in the grid by a read of the wall
// and visited store, passes over each direction that leaves the grid, and on a
// backtrack step loads the new stack top from the registered stack memory;
// on an empty stack it returns the done item. One item is handled at a time.
// Reset empties the stack, clears the visited flags and sets both dimensions
// to 16; the wall map holds no defined contents until loaded. num_rows and
// num_cols are written on the cfg port; the user must do so only while idle,
// as the block itself does not enforce this.
module grid_maze_depth_first_walk_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // cell_row, cell_col, is_wall
	input  logic [1:0]                    s_tuser,  // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // visit_row, visit_col
	output logic                          m_tlast,  // walk_done
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [gmdfw_pkg::DIM_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PROBE,
		ST_POP_WAIT,
		ST_EMIT
	} state_t;

	state_t                              state_q;
	logic [gmdfw_pkg::DEPTH_W-1:0]       depth_q;
	gmdfw_pkg::frame_t                   top_q;
	logic [gmdfw_pkg::COORD_W-1:0]       cand_row_q;
	logic [gmdfw_pkg::COORD_W-1:0]       cand_col_q;
	logic [gmdfw_pkg::COORD_W-1:0]       res_row_q;
	logic [gmdfw_pkg::COORD_W-1:0]       res_col_q;
	logic                                res_done_q;
	logic                                out_valid_q;
	logic [gmdfw_pkg::COORD_W-1:0]       out_row_q;
	logic [gmdfw_pkg::COORD_W-1:0]       out_col_q;
	logic                                out_done_q;
	logic [gmdfw_pkg::DIM_W-1:0]         num_rows_q;
	logic [gmdfw_pkg::DIM_W-1:0]         num_cols_q;

	gmdfw_pkg::grid_req_t                grid_req;
	gmdfw_pkg::grid_rsp_t                grid_rsp;
	logic                                stk_we;
	logic [gmdfw_pkg::IDX_W-1:0]         stk_waddr;
	logic                                stk_re;
	logic [gmdfw_pkg::IDX_W-1:0]         stk_raddr;
	gmdfw_pkg::frame_t                   stk_rdata;

	logic                                accept;
	logic [1:0]                          in_cmd;
	logic [3:0]                          in_row;
	logic [3:0]                          in_col;
	logic                                in_wall;
	logic                                out_free;
	logic                                cell_free;
	int                                  rows_eff;
	int                                  cols_eff;
	int                                  nr_i;
	int                                  nc_i;
	logic                                nb_ok;
	logic [gmdfw_pkg::COORD_W-1:0]       nb_row;
	logic [gmdfw_pkg::COORD_W-1:0]       nb_col;

	assign in_cmd   = s_tuser;
	assign in_row   = s_tdata[3:0];
	assign in_col   = s_tdata[7:4];
	assign in_wall  = s_tdata[8];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign cell_free = !grid_rsp.wall && !grid_rsp.visited;

	// Dimensions in use, saturated to the grid, with zero taken as one.
	always_comb begin
		if (num_rows_q == '0) begin
			rows_eff = 1;
		end else if (int'(num_rows_q) > gmdfw_pkg::MAX_DIM) begin
			rows_eff = gmdfw_pkg::MAX_DIM;
		end else begin
			rows_eff = int'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			cols_eff = 1;
		end else if (int'(num_cols_q) > gmdfw_pkg::MAX_DIM) begin
			cols_eff = gmdfw_pkg::MAX_DIM;
		end else begin
			cols_eff = int'(num_cols_q);
		end
	end

	// Neighbour of the stack top in its current direction, and whether it lies in the grid.
	always_comb begin
		nr_i = int'(top_q.row);
		nc_i = int'(top_q.col);
		case (top_q.dir)
			gmdfw_pkg::DIR_UP: begin
				nr_i = int'(top_q.row) - 1;
			end
			gmdfw_pkg::DIR_RIGHT: begin
				nc_i = int'(top_q.col) + 1;
			end
			gmdfw_pkg::DIR_DOWN: begin
				nr_i = int'(top_q.row) + 1;
			end
			gmdfw_pkg::DIR_LEFT: begin
				nc_i = int'(top_q.col) - 1;
			end
			default: begin
			end
		endcase
		nb_ok  = (nr_i >= 0) && (nr_i < rows_eff) && (nc_i >= 0) && (nc_i < cols_eff);
		nb_row = gmdfw_pkg::COORD_W'(nr_i);
		nb_col = gmdfw_pkg::COORD_W'(nc_i);
	end

	// Store and stack requests for the current step.
	always_comb begin
		grid_req  = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_re    = 1'b0;
		stk_raddr = '0;
		grid_req.wall_bit  = in_wall;
		grid_req.wall_addr = gmdfw_pkg::cell_index(gmdfw_pkg::COORD_W'(in_row),
				gmdfw_pkg::COORD_W'(in_col));
		grid_req.rd_addr   = gmdfw_pkg::cell_index(nb_row, nb_col);
		grid_req.vis_addr  = gmdfw_pkg::cell_index(cand_row_q, cand_col_q);
		stk_waddr = gmdfw_pkg::IDX_W'(depth_q - gmdfw_pkg::DEPTH_W'(1));
		stk_raddr = gmdfw_pkg::IDX_W'(depth_q - gmdfw_pkg::DEPTH_W'(2));
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_cmd == gmdfw_pkg::CMD_LOAD) &&
						(int'(in_row) < gmdfw_pkg::MAX_DIM) &&
						(int'(in_col) < gmdfw_pkg::MAX_DIM)) begin
					grid_req.wall_we = 1'b1;
				end
				if (accept && (in_cmd == gmdfw_pkg::CMD_START)) begin
					grid_req.vis_clear = 1'b1;
					grid_req.vis_set   = 1'b1;
					grid_req.vis_addr  = '0;
				end
			end
			ST_CHECK: begin
				if (depth_q != '0) begin
					if (top_q.dir == gmdfw_pkg::DIR_END) begin
						stk_re = (depth_q > gmdfw_pkg::DEPTH_W'(1));
					end else begin
						grid_req.rd_en = nb_ok;
					end
				end
			end
			ST_PROBE: begin
				if (cell_free) begin
					grid_req.vis_set = 1'b1;
					stk_we = (int'(depth_q) < gmdfw_pkg::CELLS);
				end
			end
			default: begin
			end
		endcase
	end

	// Walk sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills from the emit state and empties when taken.
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							gmdfw_pkg::CMD_START: begin
								depth_q    <= gmdfw_pkg::DEPTH_W'(1);
								top_q      <= '{row: '0, col: '0, dir: gmdfw_pkg::DIR_UP};
								res_row_q  <= '0;
								res_col_q  <= '0;
								res_done_q <= 1'b0;
								state_q    <= ST_EMIT;
							end
							gmdfw_pkg::CMD_NEXT: begin
								state_q <= ST_CHECK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (depth_q == '0) begin
						res_row_q  <= '0;
						res_col_q  <= '0;
						res_done_q <= 1'b1;
						state_q    <= ST_EMIT;
					end else if (top_q.dir == gmdfw_pkg::DIR_END) begin
						// Every direction tried: drop back to the cell below.
						depth_q <= depth_q - gmdfw_pkg::DEPTH_W'(1);
						if (depth_q > gmdfw_pkg::DEPTH_W'(1)) begin
							state_q <= ST_POP_WAIT;
						end
					end else begin
						top_q.dir <= top_q.dir + gmdfw_pkg::DIR_W'(1);
						if (nb_ok) begin
							cand_row_q <= nb_row;
							cand_col_q <= nb_col;
							state_q    <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (cell_free) begin
						if (int'(depth_q) < gmdfw_pkg::CELLS) begin
							top_q   <= '{row: cand_row_q, col: cand_col_q,
									dir: gmdfw_pkg::DIR_UP};
							depth_q <= depth_q + gmdfw_pkg::DEPTH_W'(1);
						end
						res_row_q  <= cand_row_q;
						res_col_q  <= cand_col_q;
						res_done_q <= 1'b0;
						state_q    <= ST_EMIT;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_POP_WAIT: begin
					top_q   <= stk_rdata;
					state_q <= ST_CHECK;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_row_q   <= res_row_q;
						out_col_q   <= res_col_q;
						out_done_q  <= res_done_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= gmdfw_pkg::DIM_W'(16);
			num_cols_q <= gmdfw_pkg::DIM_W'(16);
		end else if (cfg_we) begin
			case (cfg_idx)
				gmdfw_pkg::REG_NUM_ROWS: begin
					num_rows_q <= cfg_data;
				end
				gmdfw_pkg::REG_NUM_COLS: begin
					num_cols_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	gmdfw_grid_store u_grid_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (grid_req),
		.rsp    (grid_rsp)
	);

	gmdfw_stack u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (top_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'(out_col_q), 4'(out_row_q)};
	assign m_tlast  = out_done_q;

endmodule
